// File: rtl/strided_index_to_address_defines.svh
// ----------------------------------------------------------------------------
// Strided index-to-address mapper: assertion macros
// Concurrent checks, compiled out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef STRIDED_INDEX_TO_ADDRESS_DEFINES_SVH
`define STRIDED_INDEX_TO_ADDRESS_DEFINES_SVH
`ifndef SYNTHESIS
// Check a property on every rising clock edge outside reset.
`define SITA_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("%m: assertion failed");
// Check that a consequent holds in the cycle its antecedent holds.
`define SITA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: implication failed");
`else
`define SITA_ASSERT(lbl, clk, rst_n, prop)
`define SITA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/sita_pkg.sv
// ----------------------------------------------------------------------------
// sita_pkg
// Types and constants shared by the strided index-to-address mapper.
// ----------------------------------------------------------------------------
`default_nettype none

package sita_pkg;

	localparam int MAX_DIMS = 8;
	localparam int DimIdxW  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
	localparam int NdW      = $clog2(MAX_DIMS + 1);

	localparam int AddrW    = 64;
	localparam int SizeW    = 32;
	localparam int StrideW  = 64;
	localparam int IndexW   = 64;
	localparam int ItemW    = 5;
	localparam int NumDimsW = 4;
	localparam int DimSelW  = 3;
	localparam int DivCntW  = $clog2(IndexW);

	localparam int CfgIdxW  = 2;
	localparam int CfgDataW = 64;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_BASE_ADDRESS = 2'd0,
		CFG_ITEM_BYTES   = 2'd1,
		CFG_NUM_DIMS     = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		CMD_LOAD = 1'b0,
		CMD_MAP  = 1'b1
	} command_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_NULL_BASE = 2'd1,
		STAT_ZERO_DIM  = 2'd2
	} status_t;

	typedef struct packed {
		command_t                   command;
		logic [DimSelW-1:0]         dim_index;
		logic [SizeW-1:0]           dim_size;
		logic signed [StrideW-1:0]  dim_stride;
		logic [IndexW-1:0]          linear_index;
	} cmd_t;

	typedef struct packed {
		logic [AddrW-1:0] address;
		status_t          status;
	} result_t;

	typedef struct packed {
		logic [SizeW-1:0]   size;
		logic [StrideW-1:0] stride;
	} dim_entry_t;

	typedef struct packed {
		logic               en;
		logic [DimIdxW-1:0] addr;
		dim_entry_t         entry;
	} mem_wr_t;

	typedef struct packed {
		logic              start;
		logic [IndexW-1:0] dividend;
		logic [SizeW-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [IndexW-1:0] quot;
		logic [SizeW-1:0]  rem;
	} div_rsp_t;

endpackage

`default_nettype wire

// File: rtl/sita_dim_mem.sv
// ----------------------------------------------------------------------------
// sita_dim_mem
// Dimension table: size and stride per entry, one write and one registered
// read port. Per-entry valid bits make unwritten entries read as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module sita_dim_mem (
	input  wire                             clk,
	input  wire                             arst_n,
	input  sita_pkg::mem_wr_t               wr,
	input  wire                             rd_en,
	input  wire [sita_pkg::DimIdxW-1:0]     rd_addr,
	output sita_pkg::dim_entry_t            rd_data
);
	import sita_pkg::*;

	dim_entry_t             mem_q [MAX_DIMS];
	logic [MAX_DIMS-1:0]    valid_q;
	dim_entry_t             rd_data_s1;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr.en) begin
			valid_q[wr.addr] <= 1'b1;
		end
	end

	// Registered read; never-written entries return zero.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s1 <= valid_q[rd_addr] ? mem_q[rd_addr] : '0;
		end
	end

	assign rd_data = rd_data_s1;

endmodule

`default_nettype wire

// File: rtl/sita_div.sv
// ----------------------------------------------------------------------------
// sita_div
// Radix-2 restoring divider, 64-bit dividend by 32-bit divisor, one quotient
// bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sita_div (
	input  wire                 clk,
	input  wire                 arst_n,
	input  sita_pkg::div_req_t  req,
	output sita_pkg::div_rsp_t  rsp
);
	import sita_pkg::*;

	logic                busy_q;
	logic                done_q;
	logic [DivCntW-1:0]  cnt_q;
	logic [SizeW-1:0]    rem_q;
	logic [IndexW-1:0]   quot_q;
	logic [SizeW-1:0]    dvsr_q;

	logic [SizeW:0]      trial;
	logic [SizeW:0]      diff;
	logic                fits;

	// Shift the next dividend bit into the partial remainder and try a subtract.
	assign trial = {rem_q, quot_q[IndexW-1]};
	assign diff  = trial - {1'b0, dvsr_q};
	assign fits  = (trial >= {1'b0, dvsr_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			quot_q <= '0;
			dvsr_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				rem_q  <= '0;
				quot_q <= req.dividend;
				dvsr_q <= req.divisor;
			end else if (busy_q) begin
				rem_q  <= fits ? diff[SizeW-1:0] : trial[SizeW-1:0];
				quot_q <= {quot_q[IndexW-2:0], fits};
				cnt_q  <= cnt_q + DivCntW'(1);
				if (cnt_q == DivCntW'(IndexW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;
	assign rsp.rem  = rem_q;

endmodule

`default_nettype wire

// File: rtl/strided_index_to_address.sv
// ----------------------------------------------------------------------------
// strided_index_to_address
// Maps a row-major element index of a strided tensor to a byte address.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: present cmd with start high; the beat is taken at an edge
//   where busy is low. A load command writes one dimension entry (size and
//   signed stride) into the dimension table and gives no result. A map command
//   gives exactly one result beat: done is high for one cycle with result.
//   Configuration: cfg_valid/cfg_ready write base address, element size and
//   number of dimensions; write them only while the block is idle.
//   Sequencing: a map with a zero base or no dimensions returns its result in
//   the cycle after the command. Otherwise each dimension walked runs a table
//   read, a check, a pass through the shared bit-serial 64/32 divider, two
//   32x32 partial products and the accumulate, and a full map walks
//   min(num_dims, 8) dimensions. A zero-sized dimension ends the walk early.
//   Throughput: busy holds for the whole walk and drops in the result cycle,
//   so the next command can be taken in that same cycle.
//   Reset: arst_n clears the FSM, base address, dimension count and table
//   valid bits and sets element size 4; every dimension reads as size 0, stride 0.
//   The receiver cannot stall: done is high for one cycle only.
// ----------------------------------------------------------------------------
`default_nettype none
`include "strided_index_to_address_defines.svh"

module strided_index_to_address (
	input  wire                             clk,
	input  wire                             arst_n,
	// command channel
	input  wire                             start,
	output logic                            busy,
	input  sita_pkg::cmd_t                  cmd,
	// result channel
	output logic                            done,
	output sita_pkg::result_t               result,
	// configuration channel
	input  wire                             cfg_valid,
	output logic                            cfg_ready,
	input  wire [sita_pkg::CfgIdxW-1:0]     cfg_index,
	input  wire [sita_pkg::CfgDataW-1:0]    cfg_data
);
	import sita_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_CHECK,
		S_DIV,
		S_MUL_LO,
		S_MUL_HI,
		S_ACC
	} state_t;

	// configuration registers
	logic [AddrW-1:0]     base_q;
	logic [ItemW-1:0]     item_bytes_q;
	logic [NumDimsW-1:0]  num_dims_q;

	// walk state
	state_t               state_q;
	logic                 done_q;
	result_t              result_q;
	logic [DimIdxW-1:0]   k_q;
	logic [AddrW-1:0]     addr_q;
	logic [IndexW-1:0]    rem_q;
	logic [SizeW-1:0]     pos_q;
	logic [StrideW-1:0]   step_q;
	logic [AddrW-1:0]     lo_q;
	logic [SizeW-1:0]     hi_q;

	logic                 accept;
	logic [NdW-1:0]       nd_eff;
	logic                 load_ok;
	mem_wr_t              mem_wr;
	logic                 mem_rd_en;
	dim_entry_t           mem_rd_data;
	div_req_t             div_req;
	div_rsp_t             div_rsp;
	logic [AddrW-1:0]     lo_prod;
	logic [SizeW-1:0]     hi_prod;
	logic [AddrW-1:0]     addr_sum;

	assign busy      = (state_q != S_IDLE);
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;

	// Clamp the dimension count to the table depth.
	always_comb begin
		if (int'(num_dims_q) > MAX_DIMS) begin
			nd_eff = NdW'(MAX_DIMS);
		end else begin
			nd_eff = NdW'(num_dims_q);
		end
	end

	// Drop loads aimed past the table.
	assign load_ok = (int'(cmd.dim_index) < MAX_DIMS);

	assign mem_wr.en           = accept && (cmd.command == CMD_LOAD) && load_ok;
	assign mem_wr.addr         = DimIdxW'(cmd.dim_index);
	assign mem_wr.entry.size   = cmd.dim_size;
	assign mem_wr.entry.stride = cmd.dim_stride;

	assign mem_rd_en = (state_q == S_READ);

	sita_dim_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (mem_wr),
		.rd_en   (mem_rd_en),
		.rd_addr (k_q),
		.rd_data (mem_rd_data)
	);

	// Kick the divider when the entry checks out with a nonzero size.
	assign div_req.start    = (state_q == S_CHECK) && (mem_rd_data.size != '0);
	assign div_req.dividend = rem_q;
	assign div_req.divisor  = mem_rd_data.size;

	sita_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// step * pos mod 2^64 as two 32x32 partial products on separate cycles.
	assign lo_prod  = AddrW'(step_q[SizeW-1:0]) * AddrW'(pos_q);
	assign hi_prod  = step_q[StrideW-1:SizeW] * pos_q;
	assign addr_sum = addr_q + lo_q + {hi_q, {SizeW{1'b0}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q       <= '0;
			item_bytes_q <= ItemW'(4);
			num_dims_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_BASE_ADDRESS: base_q       <= cfg_data;
				CFG_ITEM_BYTES:   item_bytes_q <= cfg_data[ItemW-1:0];
				CFG_NUM_DIMS:     num_dims_q   <= cfg_data[NumDimsW-1:0];
				default:          ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			done_q   <= 1'b0;
			result_q <= '0;
			k_q      <= '0;
			addr_q   <= '0;
			rem_q    <= '0;
			pos_q    <= '0;
			step_q   <= '0;
			lo_q     <= '0;
			hi_q     <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept && (cmd.command == CMD_MAP)) begin
						if (base_q == '0) begin
							// Null tensor: answer at once.
							done_q          <= 1'b1;
							result_q.address <= '0;
							result_q.status  <= STAT_NULL_BASE;
						end else if (nd_eff == '0) begin
							done_q          <= 1'b1;
							result_q.address <= base_q;
							result_q.status  <= STAT_OK;
						end else begin
							// Walk from the last dimension in use down to the first.
							addr_q  <= base_q;
							rem_q   <= cmd.linear_index;
							k_q     <= DimIdxW'(nd_eff - NdW'(1));
							state_q <= S_READ;
						end
					end
				end
				S_READ: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (mem_rd_data.size == '0) begin
						// Zero-sized dimension: return the partial address.
						done_q           <= 1'b1;
						result_q.address <= addr_q;
						result_q.status  <= STAT_ZERO_DIM;
						state_q          <= S_IDLE;
					end else begin
						step_q  <= mem_rd_data.stride * StrideW'(item_bytes_q);
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_rsp.done) begin
						rem_q   <= div_rsp.quot;
						pos_q   <= div_rsp.rem;
						state_q <= S_MUL_LO;
					end
				end
				S_MUL_LO: begin
					lo_q    <= lo_prod;
					state_q <= S_MUL_HI;
				end
				S_MUL_HI: begin
					hi_q    <= hi_prod;
					state_q <= S_ACC;
				end
				S_ACC: begin
					addr_q <= addr_sum;
					if (k_q == '0) begin
						done_q           <= 1'b1;
						result_q.address <= addr_sum;
						result_q.status  <= STAT_OK;
						state_q          <= S_IDLE;
					end else begin
						k_q     <= k_q - DimIdxW'(1);
						state_q <= S_READ;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done   = done_q;
	assign result = result_q;

	// A result beat only appears once the walk has returned to idle.
	`SITA_ASSERT_IMPL(a_done_when_idle, clk, arst_n, done, !busy)
	// A null-base status always carries address zero.
	`SITA_ASSERT_IMPL(a_null_addr_zero, clk, arst_n,
		done && (result.status == STAT_NULL_BASE), result.address == '0)
	// The divider only finishes while the FSM waits for it.
	`SITA_ASSERT_IMPL(a_div_done_in_div, clk, arst_n, div_rsp.done, state_q == S_DIV)
	// The walk starts only from an accepted command beat.
	`SITA_ASSERT(a_busy_from_start, clk, arst_n, $rose(busy) |-> $past(start))

endmodule

`default_nettype wire
